### rtl/sorted_matrix_search_assert.svh
// Assertion macros shared by the sorted matrix search RTL.
// Each macro expands to one labelled concurrent assertion, clocked and gated by reset.
`ifndef SORTED_MATRIX_SEARCH_ASSERT_SVH
`define SORTED_MATRIX_SEARCH_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SMX_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SMX_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/smx_pkg.sv
// Package for the sorted matrix search: field widths, codes and channel payload types.
// Depends on nothing; used by the channel interfaces and the top level.
`default_nettype none

package smx_pkg;

   localparam int VALUE_WIDTH      = 32;
   localparam int INDEX_WIDTH      = 4;
   localparam int ORDER_WIDTH      = 5;
   localparam int DEF_MAX_ORDER    = 16;
   localparam int DEF_DATA_WIDTH   = 32;

   localparam logic [ORDER_WIDTH-1:0] ORDER_RESET = 5'd16;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   typedef struct packed {
      logic                          opcode;
      logic [INDEX_WIDTH-1:0]        row_index;
      logic [INDEX_WIDTH-1:0]        col_index;
      logic signed [VALUE_WIDTH-1:0] value;
   } smx_req_type;

   typedef struct packed {
      logic                   found;
      logic [INDEX_WIDTH-1:0] found_row;
      logic [INDEX_WIDTH-1:0] found_col;
   } smx_rsp_type;

endpackage

`default_nettype wire

### rtl/smx_if.sv
// Valid/ready channel interfaces for the request and response items.
// Depends on smx_pkg for the payload types.
`default_nettype none

interface smx_req_if import smx_pkg::*; ();
   logic        valid;
   logic        ready;
   smx_req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface smx_rsp_if import smx_pkg::*; ();
   logic        valid;
   logic        ready;
   smx_rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

### rtl/smx_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing.
`default_nettype none

module smx_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                                      clock,
   input  wire logic                                      wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                          wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

### rtl/sorted_matrix_search.sv
// Sorted matrix search top level: element store in one RAM, scanned by a small sequencer.
// A load item is written to the store as it is accepted. A search item holds the block,
// holding request ready low, through first column, last element, one row, result hand-off
// and return to idle, one RAM read per cycle while it scans the column and the row.
// Reset clears the sequencer and the response valid flag and sets the order to 16;
// the element store is not cleared. Depends on smx_pkg, smx_if.sv and smx_ram.
`default_nettype none

module sorted_matrix_search import smx_pkg::*; #(
   parameter int MAX_ORDER  = DEF_MAX_ORDER,
   parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   smx_req_if.sink                     req_ch,
   smx_rsp_if.source                   rsp_ch,
   input  wire logic                   csr_wr_en,
   input  wire logic [ORDER_WIDTH-1:0] csr_wr_data
);

`include "sorted_matrix_search_assert.svh"

   localparam int IDX_W  = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
   localparam int DEPTH  = MAX_ORDER * MAX_ORDER;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_COL  = 3'd1;
   localparam logic [2:0] S_LAST = 3'd2;
   localparam logic [2:0] S_ROW  = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] r,
                                                    input logic [IDX_W-1:0] c);
      cell_addr = ADDR_W'(int'(r) * MAX_ORDER + int'(c));
   endfunction

   logic [2:0]                   state_ff, state_in;
   logic [IDX_W-1:0]             k_ff, k_in;
   logic [IDX_W-1:0]             row_ff, row_in;
   logic [IDX_W-1:0]             n_last_ff, n_last_in;
   logic signed [DATA_WIDTH-1:0] key_ff, key_in;
   logic                         res_found_ff, res_found_in;
   logic [INDEX_WIDTH-1:0]       res_row_ff, res_row_in;
   logic [INDEX_WIDTH-1:0]       res_col_ff, res_col_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   smx_rsp_type                  rsp_data_ff, rsp_data_in;
   logic [ORDER_WIDTH-1:0]       csr_order_ff, csr_order_in;

   logic                         req_accept;
   logic                         slot_free;
   logic signed [DATA_WIDTH-1:0] in_word;
   logic [IDX_W-1:0]             order_last;
   logic [IDX_W-1:0]             k_next;
   logic                         load_ok;
   logic [ADDR_W-1:0]            wr_addr;
   logic [ADDR_W-1:0]            rd_addr;
   logic [DATA_WIDTH-1:0]        rd_data;
   logic signed [DATA_WIDTH-1:0] rd_word;
   logic                         hit_eq;
   logic                         hit_gt;

   assign req_ch.ready   = (state_ff == S_IDLE);
   assign req_accept     = req_ch.valid && req_ch.ready;
   assign slot_free      = !rsp_valid_ff || rsp_ch.ready;
   assign in_word        = DATA_WIDTH'(req_ch.payload.value);
   assign k_next         = k_ff + IDX_W'(1);
   assign rd_word        = $signed(rd_data);
   assign hit_eq         = (rd_word == key_ff);
   assign hit_gt         = (rd_word > key_ff);

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_data_ff;

   always_comb begin
      int n;
      n = int'(csr_order_ff);
      if (n < 1) begin
         n = 1;
      end
      if (n > MAX_ORDER) begin
         n = MAX_ORDER;
      end
      order_last = IDX_W'(n - 1);
   end

   assign load_ok = req_accept && (req_ch.payload.opcode == OP_LOAD)
                    && (int'(req_ch.payload.row_index) < MAX_ORDER)
                    && (int'(req_ch.payload.col_index) < MAX_ORDER);
   assign wr_addr = ADDR_W'(int'(req_ch.payload.row_index) * MAX_ORDER
                            + int'(req_ch.payload.col_index));

   smx_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (load_ok),
      .wr_addr (wr_addr),
      .wr_data (in_word),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      row_in       = row_ff;
      n_last_in    = n_last_ff;
      key_in       = key_ff;
      res_found_in = res_found_ff;
      res_row_in   = res_row_ff;
      res_col_in   = res_col_ff;
      rd_addr      = cell_addr(k_next, '0);
      case (state_ff)
         S_IDLE: begin
            if (req_accept && (req_ch.payload.opcode == OP_SEARCH)) begin
               key_in    = in_word;
               n_last_in = order_last;
               k_in      = '0;
               rd_addr   = cell_addr('0, '0);
               state_in  = S_COL;
            end
         end
         S_COL: begin
            if (hit_eq) begin
               res_found_in = 1'b1;
               res_row_in   = INDEX_WIDTH'(k_ff);
               res_col_in   = '0;
               state_in     = S_DONE;
            end else if (hit_gt) begin
               if (k_ff != '0) begin
                  row_in   = k_ff - IDX_W'(1);
                  k_in     = '0;
                  rd_addr  = cell_addr(k_ff - IDX_W'(1), '0);
                  state_in = S_ROW;
               end else begin
                  res_found_in = 1'b0;
                  res_row_in   = '0;
                  res_col_in   = '0;
                  state_in     = S_DONE;
               end
            end else if (k_ff == n_last_ff) begin
               rd_addr  = cell_addr(n_last_ff, n_last_ff);
               state_in = S_LAST;
            end else begin
               k_in = k_next;
            end
         end
         S_LAST: begin
            if (!hit_gt && !hit_eq) begin
               res_found_in = 1'b0;
               res_row_in   = '0;
               res_col_in   = '0;
               state_in     = S_DONE;
            end else begin
               row_in   = n_last_ff;
               k_in     = '0;
               rd_addr  = cell_addr(n_last_ff, '0);
               state_in = S_ROW;
            end
         end
         S_ROW: begin
            rd_addr = cell_addr(row_ff, k_next);
            if (hit_eq) begin
               res_found_in = 1'b1;
               res_row_in   = INDEX_WIDTH'(row_ff);
               res_col_in   = INDEX_WIDTH'(k_ff);
               state_in     = S_DONE;
            end else if (k_ff == n_last_ff) begin
               res_found_in = 1'b0;
               res_row_in   = '0;
               res_col_in   = '0;
               state_in     = S_DONE;
            end else begin
               k_in = k_next;
            end
         end
         S_DONE: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // The finished result moves into the response register once that register is free.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if ((state_ff == S_DONE) && slot_free) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.found     = res_found_ff;
         rsp_data_in.found_row = res_row_ff;
         rsp_data_in.found_col = res_col_ff;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign csr_order_in = csr_wr_en ? csr_wr_data : csr_order_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         csr_order_ff <= ORDER_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         csr_order_ff <= csr_order_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff         <= k_in;
      row_ff       <= row_in;
      n_last_ff    <= n_last_in;
      key_ff       <= key_in;
      res_found_ff <= res_found_in;
      res_row_ff   <= res_row_in;
      res_col_ff   <= res_col_in;
      rsp_data_ff  <= rsp_data_in;
   end

   `SMX_ASSERT_SAME(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff),
      $past(state_ff == S_DONE), "response raised without a finished search")
   `SMX_ASSERT_SAME(a_miss_is_zero, clock, reset, rsp_valid_ff && !rsp_data_ff.found,
      (rsp_data_ff.found_row == '0) && (rsp_data_ff.found_col == '0),
      "not-found response carries a non-zero position")
   `SMX_ASSERT_SAME(a_scan_in_range, clock, reset, (state_ff == S_COL) || (state_ff == S_ROW),
      k_ff <= n_last_ff, "scan index beyond the order in use")
   `SMX_ASSERT_NEXT(a_done_holds, clock, reset,
      (state_ff == S_DONE) && rsp_valid_ff && !rsp_ch.ready,
      state_ff == S_DONE, "finished result dropped while the response is stalled")

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 100ps
// Testbench for sorted_matrix_search: loads sorted and unsorted matrices, runs key searches
// and compares every response item with a fixed plan outcome or a local predictor. Depends
// on smx_pkg, smx_if.sv and the sorted_matrix_search RTL.

module testbench;
   import smx_pkg::*;

   localparam int ITEM_TARGET  = 1500;
   localparam int CALM_AFTER   = 1300;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 40;

   localparam smx_rsp_type NO_MATCH = '0;

   typedef struct packed {
      smx_req_type item;
      logic        typed;
      smx_rsp_type outcome;
   } plan_row_type;

   localparam int PLAN_LEN = 18;
   localparam plan_row_type PLAN [PLAN_LEN] = '{
      '{'{OP_LOAD,   4'd0,  4'd0,  -32'sd100},       1'b0, NO_MATCH},
      '{'{OP_LOAD,   4'd0,  4'd1,  -32'sd5},         1'b0, NO_MATCH},
      '{'{OP_LOAD,   4'd1,  4'd0,  32'sd7},          1'b0, NO_MATCH},
      '{'{OP_LOAD,   4'd1,  4'd1,  32'sh7FFFFFFF},   1'b0, NO_MATCH},
      '{'{OP_LOAD,   4'd15, 4'd15, 32'sh80000000},   1'b0, NO_MATCH},
      '{'{OP_LOAD,   4'd15, 4'd0,  32'sd0},          1'b0, NO_MATCH},
      '{'{OP_SEARCH, 4'd15, 4'd15, 32'sh80000000},   1'b1, NO_MATCH},
      '{'{OP_SEARCH, 4'd0,  4'd0,  32'sh7FFFFFFF},   1'b1, '{1'b1, 4'd1, 4'd1}},
      '{'{OP_SEARCH, 4'd0,  4'd15, -32'sd100},       1'b1, '{1'b1, 4'd0, 4'd0}},
      '{'{OP_SEARCH, 4'd15, 4'd0,  -32'sd5},         1'b0, NO_MATCH},
      '{'{OP_SEARCH, 4'd3,  4'd9,  32'sd0},          1'b0, NO_MATCH},
      '{'{OP_SEARCH, 4'd0,  4'd0,  32'sd7},          1'b1, '{1'b1, 4'd1, 4'd0}},
      '{'{OP_SEARCH, 4'd0,  4'd0,  32'sd100},        1'b0, NO_MATCH},
      '{'{OP_SEARCH, 4'd0,  4'd0,  -32'sd101},       1'b1, NO_MATCH},
      '{'{OP_LOAD,   4'd1,  4'd1,  32'sd1000},       1'b0, NO_MATCH},
      '{'{OP_SEARCH, 4'd0,  4'd0,  32'sd2000},       1'b1, NO_MATCH},
      '{'{OP_SEARCH, 4'd0,  4'd0,  32'sd1000},       1'b0, NO_MATCH},
      '{'{OP_SEARCH, 4'd0,  4'd0,  32'sd8},          1'b0, NO_MATCH}
   };

   logic                   clock;
   logic                   reset;
   logic                   csr_wr_en;
   logic [ORDER_WIDTH-1:0] csr_wr_data;

   smx_req_if req_ch ();
   smx_rsp_if rsp_ch ();

   sorted_matrix_search u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   logic signed [VALUE_WIDTH-1:0] grid [DEF_MAX_ORDER][DEF_MAX_ORDER];
   logic [ORDER_WIDTH-1:0]        order_sel;
   smx_rsp_type                   search_outcomes [$];

   int mismatches  = 0;
   int items_taken = 0;
   int idle_cycles = 0;
   int gap_pct     = 0;
   int stall_pct   = 0;
   int stall_left  = 0;
   bit calm        = 1'b0;

   always #5 clock = ~clock;

   function automatic int eff_order(input logic [ORDER_WIDTH-1:0] v);
      if (v == 0) return 1;
      if (v > DEF_MAX_ORDER) return DEF_MAX_ORDER;
      return int'(v);
   endfunction

   function automatic smx_rsp_type locate_key(input logic signed [VALUE_WIDTH-1:0] key);
      smx_rsp_type res;
      int          n;
      int          r;
      int          k;
      bit          have_row;
      bit          done;
      res      = NO_MATCH;
      n        = eff_order(order_sel);
      r        = 0;
      have_row = 1'b0;
      done     = 1'b0;
      for (k = 0; k < n && !done; k++) begin
         if (grid[k][0] == key) begin
            r        = k;
            have_row = 1'b1;
            done     = 1'b1;
         end else if (grid[k][0] > key) begin
            if (k > 0) begin
               r        = k - 1;
               have_row = 1'b1;
            end
            done = 1'b1;
         end
      end
      if (!done && grid[n-1][n-1] >= key) begin
         r        = n - 1;
         have_row = 1'b1;
      end
      if (have_row) begin
         done = 1'b0;
         for (k = 0; k < n && !done; k++) begin
            if (grid[r][k] == key) begin
               res.found     = 1'b1;
               res.found_row = r[INDEX_WIDTH-1:0];
               res.found_col = k[INDEX_WIDTH-1:0];
               done          = 1'b1;
            end
         end
      end
      return res;
   endfunction

   function automatic int pick_pct();
      case ($urandom_range(0, 2))
         0: return 0;
         1: return 15;
         default: return 50;
      endcase
   endfunction

   task automatic flag_mismatch(input string why);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", why);
   endtask

   // Called at a falling edge; returns at the falling edge after the item is taken.
   task automatic offer_item(input smx_req_type item, input bit typed,
                             input smx_rsp_type outcome);
      if (!calm && $urandom_range(0, 99) < gap_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= item;
      do @(posedge clock); while (!req_ch.ready);
      if (item.opcode == OP_LOAD) begin
         grid[item.row_index][item.col_index] = item.value;
      end else if (typed) begin
         search_outcomes.push_back(outcome);
      end else begin
         search_outcomes.push_back(locate_key(item.value));
      end
      items_taken++;
      @(negedge clock);
   endtask

   task automatic settle();
      req_ch.valid <= 1'b0;
      while (search_outcomes.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_order(input logic [ORDER_WIDTH-1:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      order_sel = v;
   endtask

   always @(negedge clock) begin
      if (stall_left != 0) begin
         stall_left--;
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
         stall_left = $urandom_range(1, 9);
      end
      rsp_ch.ready <= (stall_left == 0);
   end

   always @(posedge clock) begin
      smx_rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (search_outcomes.size() == 0) begin
            flag_mismatch($sformatf("unexpected item found=%0b row=%0d col=%0d",
               rsp_ch.payload.found, rsp_ch.payload.found_row, rsp_ch.payload.found_col));
         end else begin
            want = search_outcomes.pop_front();
            if (rsp_ch.payload.found !== want.found
                  || rsp_ch.payload.found_row !== want.found_row
                  || rsp_ch.payload.found_col !== want.found_col) begin
               flag_mismatch($sformatf("expected %0b/%0d/%0d, got %0b/%0d/%0d",
                  want.found, want.found_row, want.found_col, rsp_ch.payload.found,
                  rsp_ch.payload.found_row, rsp_ch.payload.found_col));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      smx_req_type item;
      int          i;
      int          n;
      int          cfg;
      int          phase;
      int          r;
      int          c;
      int          k;
      int          draw;
      bit          sorted;
      bit          top_max;
      longint      stepmax;
      longint      span;
      longint      cur;

      clock          = 1'b0;
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready   = 1'b0;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      order_sel      = ORDER_RESET;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      write_order(5'd2);
      for (i = 0; i < PLAN_LEN; i++) begin
         offer_item(PLAN[i].item, PLAN[i].typed, PLAN[i].outcome);
      end

      phase = 0;
      while (items_taken < ITEM_TARGET) begin
         settle();
         case (phase)
            0: cfg = 31;
            1: cfg = 0;
            2: cfg = 1;
            3: cfg = 16;
            default: cfg = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 31)
                                                       : $urandom_range(1, 8);
         endcase
         write_order(cfg[ORDER_WIDTH-1:0]);
         n         = eff_order(cfg[ORDER_WIDTH-1:0]);
         gap_pct   = pick_pct();
         stall_pct = pick_pct();
         if (items_taken >= CALM_AFTER) calm = 1'b1;

         // The first pass fills the whole store, so later searches never read stale cells.
         if (phase < 4 || n <= 8) begin
            sorted  = ($urandom_range(0, 5) != 0);
            top_max = ($urandom_range(0, 5) == 0);
            case ($urandom_range(0, 2))
               0: stepmax = 1;
               1: stepmax = 8;
               default: stepmax = 64'd1 << 22;
            endcase
            span = n * n * stepmax;
            if ($urandom_range(0, 3) == 0) begin
               cur = -64'sd2147483648;
            end else begin
               cur = -64'sd2147483648 + (longint'($urandom) % (64'sd4294967296 - span));
            end
            for (r = 0; r < n; r++) begin
               for (c = 0; c < n; c++) begin
                  item.opcode    = OP_LOAD;
                  item.row_index = r[INDEX_WIDTH-1:0];
                  item.col_index = c[INDEX_WIDTH-1:0];
                  item.value     = sorted ? cur[VALUE_WIDTH-1:0] : $urandom;
                  if (sorted && top_max && r == n - 1 && c == n - 1) begin
                     item.value = 32'sh7FFFFFFF;
                  end
                  offer_item(item, 1'b0, NO_MATCH);
                  cur = cur + $urandom_range(0, int'(stepmax));
               end
            end
         end else begin
            for (k = 0; k < 8; k++) begin
               item.opcode    = OP_LOAD;
               item.row_index = $urandom_range(0, 15);
               item.col_index = $urandom_range(0, 15);
               item.value     = $urandom;
               offer_item(item, 1'b0, NO_MATCH);
            end
         end

         for (k = $urandom_range(16, 48); k > 0; k--) begin
            item.row_index = $urandom_range(0, 15);
            item.col_index = $urandom_range(0, 15);
            if ($urandom_range(0, 19) == 0) begin
               item.opcode = OP_LOAD;
               item.value  = $urandom;
            end else begin
               item.opcode = OP_SEARCH;
               r    = $urandom_range(0, n - 1);
               c    = $urandom_range(0, n - 1);
               draw = $urandom_range(0, 9);
               if (draw <= 5) begin
                  item.value = grid[r][c];
               end else if (draw <= 7) begin
                  item.value = grid[r][c] + ($urandom_range(0, 1) ? 32'sd1 : -32'sd1);
               end else if (draw == 8) begin
                  item.value = $urandom;
               end else begin
                  item.value = $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
               end
            end
            offer_item(item, 1'b0, NO_MATCH);
         end
         phase++;
      end

      req_ch.valid <= 1'b0;
      while (search_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule

### sorted_matrix_search.f
+incdir+rtl
rtl/smx_pkg.sv
rtl/smx_if.sv
rtl/smx_ram.sv
rtl/sorted_matrix_search.sv
tb/testbench.sv
